// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked, reset-gated implication forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// File: hdl/owrs_pkg.sv
// ----------------------------------------------------------------------------
// owrs_pkg
// Types and constants for the 1-Wire ROM search decision engine.
// ----------------------------------------------------------------------------
package owrs_pkg;

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 3;

   // Search geometry
   localparam int ROM_W      = 64;
   localparam int IDX_W      = 6;
   localparam int POS_W      = 7;
   localparam int FAM_W      = 4;

   localparam logic [POS_W-1:0] ROM_BITS_END = POS_W'(65);
   localparam logic [POS_W-1:0] FAMILY_LIMIT = POS_W'(9);
   localparam logic [POS_W-1:0] FIRST_POS    = POS_W'(1);

   // Request kinds carried on req_tuser
   typedef enum logic [REQ_USER_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_START    = 2'd1,
      CMD_BIT_PAIR = 2'd2
   } cmd_type;

   // Result kinds carried on rsp_tuser
   typedef enum logic [RSP_USER_W-1:0] {
      ST_IGNORED      = 3'd0,
      ST_STARTED      = 3'd1,
      ST_BIT_CHOSEN   = 3'd2,
      ST_DEVICE_FOUND = 3'd3,
      ST_NO_DEVICE    = 3'd4
   } status_type;

endpackage

// File: hdl/one_wire_rom_search.sv
// ----------------------------------------------------------------------------
// one_wire_rom_search
// Decision engine for the 1-Wire ROM search: picks the direction bit for
// each id/complement pair and tracks discrepancies across search passes.
// ----------------------------------------------------------------------------
//  Channel | Dir | tuser          | tdata
//  req_    | in  | command        | presence_ok, true_bit, complement_bit
//  rsp_    | out | status         | write_valid, direction_bit, rom_value,
//          |     |                | last_device, family_discrepancy
//
//  Each request's result is registered into the output register at the
//  next edge; a new request is taken in the same cycle as the pending
//  result is taken, or whenever no result is pending.
//  Synchronous reset clears the search context and the ROM register.
//  A stalled result holds the request side; one result is buffered.
// ----------------------------------------------------------------------------
module one_wire_rom_search (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] presence_ok, [1] true_bit, [2] complement_bit, [7:3] zero
   input  logic [owrs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command
   input  logic [owrs_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] write_valid, [1] direction_bit, [65:2] rom_value, [66] last_device,
   // [70:67] family_discrepancy, [71] zero
   output logic [owrs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] status
   output logic [owrs_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import owrs_pkg::*;

   // Search state
   logic [ROM_W-1:0] rom_ff,      rom_in;
   logic [POS_W-1:0] last_disc_ff, last_disc_in;
   logic [FAM_W-1:0] fam_disc_ff, fam_disc_in;
   logic             finished_ff, finished_in;
   logic [POS_W-1:0] bit_pos_ff,  bit_pos_in;
   logic [POS_W-1:0] zero_pos_ff, zero_pos_in;
   logic             searching_ff, searching_in;

   // Result register
   logic             rsp_valid_ff;
   status_type       status_ff,   status_in;
   logic             wr_valid_ff, wr_valid_in;
   logic             dir_ff,      dir_in;
   logic             last_dev_ff, last_dev_in;

   logic             req_fire;
   logic [IDX_W-1:0] bit_idx;
   logic [POS_W-1:0] next_pos;
   logic             presence;
   logic             id_bit;
   logic             cmp_bit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign presence = req_tdata[0];
   assign id_bit   = req_tdata[1];
   assign cmp_bit  = req_tdata[2];
   assign bit_idx  = IDX_W'(bit_pos_ff - FIRST_POS);
   assign next_pos = bit_pos_ff + FIRST_POS;

   // Decide the result and the next search state for one request
   always_comb begin
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      fam_disc_in  = fam_disc_ff;
      finished_in  = finished_ff;
      bit_pos_in   = bit_pos_ff;
      zero_pos_in  = zero_pos_ff;
      searching_in = searching_ff;
      status_in    = ST_IGNORED;
      wr_valid_in  = 1'b0;
      dir_in       = 1'b0;
      last_dev_in  = 1'b0;

      unique case (req_tuser)
         CMD_CLEAR: begin
            last_disc_in = '0;
            fam_disc_in  = '0;
            finished_in  = 1'b0;
            searching_in = 1'b0;
            bit_pos_in   = FIRST_POS;
            zero_pos_in  = '0;
            status_in    = ST_NO_DEVICE;
         end
         CMD_START: begin
            bit_pos_in   = FIRST_POS;
            zero_pos_in  = '0;
            if (finished_ff || !presence) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               finished_in  = 1'b0;
               searching_in = 1'b0;
               status_in    = ST_NO_DEVICE;
            end else begin
               searching_in = 1'b1;
               status_in    = ST_STARTED;
            end
         end
         CMD_BIT_PAIR: begin
            if (searching_ff) begin
               if (id_bit && cmp_bit) begin
                  // no device answered: drop the pass
                  last_disc_in = '0;
                  fam_disc_in  = '0;
                  finished_in  = 1'b0;
                  searching_in = 1'b0;
                  bit_pos_in   = FIRST_POS;
                  zero_pos_in  = '0;
                  status_in    = ST_NO_DEVICE;
               end else begin
                  // pick the direction: agreed bit, or follow the search tree
                  if (id_bit != cmp_bit) begin
                     dir_in = id_bit;
                  end else begin
                     if (bit_pos_ff < last_disc_ff) begin
                        dir_in = rom_ff[bit_idx];
                     end else begin
                        dir_in = (bit_pos_ff == last_disc_ff);
                     end
                     if (!dir_in) begin
                        zero_pos_in = bit_pos_ff;
                        if (bit_pos_ff < FAMILY_LIMIT) begin
                           fam_disc_in = bit_pos_ff[FAM_W-1:0];
                        end
                     end
                  end
                  rom_in[bit_idx] = dir_in;
                  wr_valid_in     = 1'b1;
                  bit_pos_in      = next_pos;
                  status_in       = ST_BIT_CHOSEN;

                  // close the pass after the last ROM bit
                  if (next_pos >= ROM_BITS_END) begin
                     last_disc_in = zero_pos_in;
                     finished_in  = (zero_pos_in == '0);
                     searching_in = 1'b0;
                     bit_pos_in   = FIRST_POS;
                     zero_pos_in  = '0;
                     if (rom_in[7:0] == 8'h00) begin
                        last_disc_in = '0;
                        fam_disc_in  = '0;
                        finished_in  = 1'b0;
                        status_in    = ST_NO_DEVICE;
                     end else begin
                        status_in    = ST_DEVICE_FOUND;
                        last_dev_in  = finished_in;
                     end
                  end
               end
            end
         end
         default: begin
            status_in = ST_IGNORED;
         end
      endcase
   end

   // Update search state on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff       <= '0;
         last_disc_ff <= '0;
         fam_disc_ff  <= '0;
         finished_ff  <= 1'b0;
         bit_pos_ff   <= FIRST_POS;
         zero_pos_ff  <= '0;
         searching_ff <= 1'b0;
      end else if (req_fire) begin
         rom_ff       <= rom_in;
         last_disc_ff <= last_disc_in;
         fam_disc_ff  <= fam_disc_in;
         finished_ff  <= finished_in;
         bit_pos_ff   <= bit_pos_in;
         zero_pos_ff  <= zero_pos_in;
         searching_ff <= searching_in;
      end
   end

   // Hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff   <= status_in;
         wr_valid_ff <= wr_valid_in;
         dir_ff      <= dir_in;
         last_dev_ff <= last_dev_in;
      end
   end

   // The ROM and family discrepancy outputs show the state after the transfer
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, fam_disc_ff, last_dev_ff, rom_ff, dir_ff, wr_valid_ff};

endmodule

// File: hdl/owrs_checker.sv
// ----------------------------------------------------------------------------
// owrs_checker
// Port-level checks for the ROM search engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owrs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [owrs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [owrs_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [owrs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [owrs_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import owrs_pkg::*;

   logic req_fire;
   logic rsp_stall;
   logic ctx_clear;
   logic rsp_cleared;
   logic write_kind;

   assign req_fire    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   // A clear, or a start without a presence pulse, drops the context
   assign ctx_clear   = req_fire && (req_tuser == CMD_CLEAR ||
                                     (req_tuser == CMD_START && !req_tdata[0]));
   assign rsp_cleared = (rsp_tuser == ST_NO_DEVICE) && (rsp_tdata[70:67] == 4'd0);
   assign write_kind  = rsp_tuser == ST_BIT_CHOSEN || rsp_tuser == ST_DEVICE_FOUND ||
                        rsp_tuser == ST_NO_DEVICE;

   // A stalled result keeps its contents
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable({rsp_tuser, rsp_tdata}))

   // A context drop yields a cleared-context result with no family discrepancy
   `ASSERT_NEXT(a_clear_result, clock, reset, ctx_clear, rsp_tvalid && rsp_cleared)

   // A bus write comes only with a bit-chosen, device-found or no-device status
   `ASSERT_SAME(a_write_kind, clock, reset, rsp_tvalid && rsp_tdata[0], write_kind)

   // The final-device flag appears only with a found device
   `ASSERT_SAME(a_last_device, clock, reset, rsp_tvalid && rsp_tdata[66], rsp_tuser == ST_DEVICE_FOUND)

   // No direction bit without a bus write
   `ASSERT_SAME(a_dir_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], !rsp_tdata[1])

endmodule

bind one_wire_rom_search owrs_checker u_owrs_checker (.*);
